// ===== hw/rtl/hsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfd_pkg
// Constants and helpers for the humidity sensor frame decoder: CRC-8 step,
// rounded scaling of a raw 16-bit word, and status codes.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    localparam int unsigned FieldW  = 8;
    localparam int unsigned WordW   = 16;
    localparam int unsigned StatusW = 2;
    localparam int unsigned TempW   = 9;
    localparam int unsigned HumiW   = 7;
    localparam int unsigned InDataW  = 6 * FieldW;
    localparam int unsigned OutBitsW = StatusW + TempW + HumiW;
    localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;
    localparam int unsigned ProdW    = 24;
    localparam int unsigned QuotW    = 8;

    localparam logic [7:0] CrcPoly = 8'h31;
    localparam logic [7:0] CrcInit = 8'hFF;

    localparam logic [7:0]  TempScale = 8'd175;
    localparam logic [7:0]  HumiScale = 8'd125;
    localparam logic [15:0] RoundHalf = 16'd32767;
    localparam logic [16:0] FullScale = 17'd65535;

    localparam logic [8:0] TempOffset = 9'd45;
    localparam logic [7:0] HumiOffset = 8'd6;
    localparam logic [7:0] HumiTop    = 8'd106;
    localparam logic [6:0] HumiMax    = 7'd100;

    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_TEMP_CRC = 2'd1;
    localparam logic [StatusW-1:0] ST_HUMI_CRC = 2'd2;

    typedef struct packed {
        logic [FieldW-1:0] humi_check;
        logic [FieldW-1:0] humi_lsb;
        logic [FieldW-1:0] humi_msb;
        logic [FieldW-1:0] temp_check;
        logic [FieldW-1:0] temp_lsb;
        logic [FieldW-1:0] temp_msb;
    } t_frame;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CrcPoly;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // round(scale * raw / 65535); x / 65535 = x[23:16] + one correction step
    function automatic logic [QuotW-1:0] scale_round(input logic [WordW-1:0] raw,
                                                     input logic [7:0] scale);
        logic [ProdW-1:0] x;
        logic [QuotW-1:0] q0;
        logic [16:0]      rem;
        x   = ProdW'(raw) * ProdW'(scale) + ProdW'(RoundHalf);
        q0  = x[ProdW-1:WordW];
        rem = {1'b0, x[WordW-1:0]} + 17'(q0);
        return (rem >= FullScale) ? q0 + QuotW'(1) : q0;
    endfunction

endpackage

// ===== hw/rtl/humidity_sensor_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Checks both CRC-8 bytes of a six-byte measurement frame and converts the
// raw words to whole degrees Celsius and whole percent humidity.
// ----------------------------------------------------------------------------
// Accepted frames pass through the input reg, then the result reg.
// Throughput: one item per cycle; decode is one pass of CRC and scaling logic.
// A full result register only stalls the input while the output is blocked.
// Reset (synchronous, active low) empties both stages; no other state.
module humidity_sensor_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] temp_msb, [15:8] temp_lsb, [23:16] temp_check,
    // [31:24] humi_msb, [39:32] humi_lsb, [47:40] humi_check
    input  logic [hsfd_pkg::InDataW-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [10:2] temperature, [17:11] humidity, [23:18] zero
    output logic [hsfd_pkg::OutDataW-1:0] m_axis_tdata
);

    logic                  r_s1_vld;
    hsfd_pkg::t_frame      r_s1_frame;
    logic                  r_out_vld;
    logic [hsfd_pkg::OutDataW-1:0] r_out_data;

    logic                  out_ready;
    logic                  s1_ready;

    logic [7:0]            t_crc;
    logic [7:0]            h_crc;
    logic [hsfd_pkg::QuotW-1:0] t_q;
    logic [hsfd_pkg::QuotW-1:0] h_q;
    logic [hsfd_pkg::StatusW-1:0] status;
    logic [hsfd_pkg::TempW-1:0]   temp;
    logic [hsfd_pkg::HumiW-1:0]   humi;
    logic [hsfd_pkg::OutDataW-1:0] n_out_data;

    assign out_ready     = !r_out_vld || m_axis_tready;
    assign s1_ready      = !r_s1_vld || out_ready;
    assign s_axis_tready = s1_ready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        t_crc = hsfd_pkg::crc8_byte(hsfd_pkg::crc8_byte(hsfd_pkg::CrcInit,
                    r_s1_frame.temp_msb), r_s1_frame.temp_lsb);
        h_crc = hsfd_pkg::crc8_byte(hsfd_pkg::crc8_byte(hsfd_pkg::CrcInit,
                    r_s1_frame.humi_msb), r_s1_frame.humi_lsb);
        t_q = hsfd_pkg::scale_round({r_s1_frame.temp_msb, r_s1_frame.temp_lsb},
                                    hsfd_pkg::TempScale);
        h_q = hsfd_pkg::scale_round({r_s1_frame.humi_msb, r_s1_frame.humi_lsb},
                                    hsfd_pkg::HumiScale);

        priority if (t_crc != r_s1_frame.temp_check) begin
            status = hsfd_pkg::ST_TEMP_CRC;
        end else if (h_crc != r_s1_frame.humi_check) begin
            status = hsfd_pkg::ST_HUMI_CRC;
        end else begin
            status = hsfd_pkg::ST_OK;
        end

        priority if (status != hsfd_pkg::ST_OK) begin
            temp = '0;
            humi = '0;
        end else begin
            temp = {1'b0, t_q} - hsfd_pkg::TempOffset;
            if (h_q < hsfd_pkg::HumiOffset) begin
                humi = '0;
            end else if (h_q > hsfd_pkg::HumiTop) begin
                humi = hsfd_pkg::HumiMax;
            end else begin
                humi = hsfd_pkg::HumiW'(h_q - hsfd_pkg::HumiOffset);
            end
        end

        n_out_data = '0;
        n_out_data[hsfd_pkg::OutBitsW-1:0] = {humi, temp, status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s1_ready) begin
            r_s1_frame <= hsfd_pkg::t_frame'(s_axis_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && out_ready) begin
            r_out_data <= n_out_data;
        end
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("status code 3 produced");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != hsfd_pkg::ST_OK))
        |-> (m_axis_tdata[hsfd_pkg::OutDataW-1:hsfd_pkg::StatusW] == '0))
        else $error("values nonzero on CRC failure");

    a_humi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:11] <= hsfd_pkg::HumiMax))
        else $error("humidity above clamp");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_ready) |=> (r_s1_vld && $stable(r_s1_frame)))
        else $error("stalled frame lost");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && out_ready) |=> r_out_vld)
        else $error("decoded frame not loaded");

endmodule

// ===== test/frame_decode_checker.sv =====
// ----------------------------------------------------------------------------
// frame_decode_checker
// Watches both stream channels of the humidity sensor frame decoder. Every
// accepted frame is decoded here (CRC-8 of both words, rounded conversion,
// humidity clamp) and the measurement is queued; every accepted result is
// compared field by field with the oldest queued measurement.
// ----------------------------------------------------------------------------
module frame_decode_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [hsfd_pkg::InDataW-1:0]  i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [hsfd_pkg::OutDataW-1:0] i_m_tdata,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [hsfd_pkg::StatusW-1:0]      status;
        logic signed [hsfd_pkg::TempW-1:0] temperature;
        logic [hsfd_pkg::HumiW-1:0]        humidity;
    } t_meas;

    t_meas expected_meas[$];
    int    mismatch_cnt = 0;
    int    pending_cnt  = 0;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = pending_cnt;

    // MSB-first CRC over the whole 16-bit word
    function automatic logic [7:0] word_crc(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] w;
        logic [7:0]  c;
        logic        fb;
        w = {hi, lo};
        c = hsfd_pkg::CrcInit;
        for (int i = 15; i >= 0; i--) begin
            fb = c[7] ^ w[i];
            c  = {c[6:0], 1'b0} ^ (fb ? hsfd_pkg::CrcPoly : 8'h00);
        end
        return c;
    endfunction

    function automatic int rounded_scale(input int unsigned raw, input int unsigned k);
        return int'((k * raw + 32'd32767) / 32'd65535);
    endfunction

    function automatic t_meas decode_frame(input hsfd_pkg::t_frame f);
        t_meas m;
        int    t;
        int    h;
        m = '0;
        if (word_crc(f.temp_msb, f.temp_lsb) != f.temp_check) begin
            m.status = hsfd_pkg::ST_TEMP_CRC;
        end else if (word_crc(f.humi_msb, f.humi_lsb) != f.humi_check) begin
            m.status = hsfd_pkg::ST_HUMI_CRC;
        end else begin
            t = -45 + rounded_scale(32'({f.temp_msb, f.temp_lsb}), 32'd175);
            h = -6 + rounded_scale(32'({f.humi_msb, f.humi_lsb}), 32'd125);
            if (h < 0) h = 0;
            if (h > 100) h = 100;
            m.status      = hsfd_pkg::ST_OK;
            m.temperature = t[hsfd_pkg::TempW-1:0];
            m.humidity    = h[hsfd_pkg::HumiW-1:0];
        end
        return m;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_meas got;
        t_meas want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expected_meas.push_back(decode_frame(hsfd_pkg::t_frame'(i_s_tdata)));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status      = i_m_tdata[1:0];
                got.temperature = i_m_tdata[10:2];
                got.humidity    = i_m_tdata[17:11];
                if (expected_meas.size() == 0) begin
                    report_mismatch("unexpected result status", int'(got.status), -1);
                end else begin
                    want = expected_meas.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.temperature != want.temperature)
                        report_mismatch("temperature", int'(got.temperature),
                                        int'(want.temperature));
                    if (got.humidity != want.humidity)
                        report_mismatch("humidity", int'(got.humidity), int'(want.humidity));
                end
            end
            pending_cnt = expected_meas.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives measurement frames into the humidity sensor frame decoder: a short
// directed set (range extremes, clamp edges, each CRC failure case), then
// random frames, mostly with correct CRCs, across phases of source idling
// and sink stalling, including one long sink hold-off. Verdict comes from
// the checker's mismatch count and a no-progress watchdog.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PhaseItems = 235;
    localparam int HoldCycles = 300;
    localparam int StallLimit = 2000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // temp_msb, temp_lsb, temp_check, humi_msb, humi_lsb, humi_check
    logic [hsfd_pkg::InDataW-1:0]  s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // status, temperature, humidity, zero pad
    logic [hsfd_pkg::OutDataW-1:0] m_axis_tdata;

    int   mismatches;
    int   outstanding;
    int   src_idle_pct;
    int   sink_stall_pct;
    logic hold_req;
    int   quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    humidity_sensor_frame_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    frame_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    // flips are xor masks on the check bytes; zero keeps the CRC correct
    function automatic hsfd_pkg::t_frame make_frame(input logic [15:0] raw_t,
                                                    input logic [15:0] raw_h,
                                                    input logic [7:0] t_flip,
                                                    input logic [7:0] h_flip);
        hsfd_pkg::t_frame f;
        f.temp_msb   = raw_t[15:8];
        f.temp_lsb   = raw_t[7:0];
        f.temp_check = hsfd_pkg::crc8_byte(hsfd_pkg::crc8_byte(hsfd_pkg::CrcInit,
                           raw_t[15:8]), raw_t[7:0]) ^ t_flip;
        f.humi_msb   = raw_h[15:8];
        f.humi_lsb   = raw_h[7:0];
        f.humi_check = hsfd_pkg::crc8_byte(hsfd_pkg::crc8_byte(hsfd_pkg::CrcInit,
                           raw_h[15:8]), raw_h[7:0]) ^ h_flip;
        return f;
    endfunction

    function automatic logic [15:0] random_raw();
        unique case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            3:       return 16'($urandom_range(65280, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic hsfd_pkg::t_frame random_frame();
        int         pick;
        logic [7:0] t_flip;
        logic [7:0] h_flip;
        pick   = $urandom_range(0, 99);
        t_flip = 8'h00;
        h_flip = 8'h00;
        if (pick < 5) return hsfd_pkg::t_frame'(48'({$urandom, $urandom}));
        if (pick >= 70 && pick < 80) t_flip = 8'($urandom_range(1, 255));
        if (pick >= 80 && pick < 90) h_flip = 8'($urandom_range(1, 255));
        if (pick >= 90) begin
            t_flip = 8'($urandom_range(1, 255));
            h_flip = 8'($urandom_range(1, 255));
        end
        return make_frame(random_raw(), random_raw(), t_flip, h_flip);
    endfunction

    task automatic send_frame(input hsfd_pkg::t_frame f);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // sink side: random stalls, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        hold_req       = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // range extremes
        send_frame(make_frame(16'h0000, 16'h0000, 8'h00, 8'h00));
        send_frame(make_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00));
        send_frame(make_frame(16'h8000, 16'h7FFF, 8'h00, 8'h00));
        send_frame(make_frame(16'h0001, 16'hFFFE, 8'h00, 8'h00));
        send_frame(make_frame(16'h00FF, 16'hFF00, 8'h00, 8'h00));
        send_frame(make_frame(16'hFF00, 16'h00FF, 8'h00, 8'h00));
        send_frame(make_frame(16'hAAAA, 16'h5555, 8'h00, 8'h00));
        // humidity clamp edges, low and high
        send_frame(make_frame(16'h6666, 16'h0B43, 8'h00, 8'h00));
        send_frame(make_frame(16'h6666, 16'h0B44, 8'h00, 8'h00));
        send_frame(make_frame(16'h6666, 16'hDA1B, 8'h00, 8'h00));
        send_frame(make_frame(16'h6666, 16'hDA1C, 8'h00, 8'h00));
        // temperature check byte wrong
        send_frame(make_frame(16'h1234, 16'h5678, 8'h01, 8'h00));
        send_frame(make_frame(16'hFFFF, 16'h0000, 8'h80, 8'h00));
        // humidity check byte wrong
        send_frame(make_frame(16'h1234, 16'h5678, 8'h00, 8'h01));
        send_frame(make_frame(16'h0000, 16'hFFFF, 8'h00, 8'hFF));
        // both wrong: temperature failure wins
        send_frame(make_frame(16'h1234, 16'h5678, 8'h10, 8'h20));
        send_frame(make_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        send_frame(hsfd_pkg::t_frame'(48'h0));
        send_frame(hsfd_pkg::t_frame'({48{1'b1}}));

        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct = 80; sink_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct <= 80; end
                default: begin src_idle_pct = 36; sink_stall_pct <= 36; end
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                if (phase == 0 && n == 100) hold_req <= 1'b1;
                send_frame(random_frame());
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
